FILE: sv/assert_macros.svh
// assertion macros used by the datapath rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/lphm_pkg.sv
// types and constants of the linear probing hash map
package lphm_pkg;

	localparam logic CMD_SET = 1'b0;
	localparam logic CMD_GET = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TYPE    = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	localparam logic [63:0] MIX_MUL   = 64'hff51afd7ed558ccd;
	localparam int          MIX_SHIFT = 33;
	localparam int          LOAD_NUM  = 7;
	localparam int          LOAD_DEN  = 10;

	typedef struct packed {
		logic               command;
		logic               key_is_integer;
		logic signed [63:0] key;
		logic [3:0]         value_tag;
		logic [63:0]        value_payload;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [3:0]  result_tag;
		logic [63:0] result_payload;
		logic        hint_valid;
		logic [3:0]  hint_kind;
	} out_item_t;

	typedef struct packed {
		logic        used;
		logic [63:0] key;
		logic [3:0]  tag;
		logic [63:0] payload;
	} slot_t;

	typedef enum logic [2:0] {
		OC_TYPE,
		OC_MISSING,
		OC_FULL,
		OC_GET_HIT,
		OC_OVERWRITE,
		OC_INSERT
	} outcome_t;

	typedef struct packed {
		logic     clr;
		logic     load;
		logic     probe_load;
		logic     probe_run;
		logic     finish;
		outcome_t outcome;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic key_ok;
		logic is_get;
		logic hash_done;
		logic ev_valid;
		logic ev_hit;
		logic ev_empty;
		logic ev_last;
		logic full;
	} dp_stat_t;

endpackage

FILE: sv/lphm_hash.sv
// home slot unit: 64-bit mix on a shared 32x32 multiplier, then reduction to the table size
module lphm_hash
	import lphm_pkg::*;
#(
	parameter int SLOTS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [63:0]                key,
	output logic                       done,
	output logic [$clog2(SLOTS)-1:0]   home
);

	localparam int AW   = $clog2(SLOTS);
	localparam bit POW2 = (SLOTS == (1 << AW));
	localparam int LAST = POW2 ? 4 : 36;
	localparam int SW   = $clog2(LAST + 1);

	logic          run_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [63:0]   x_q;
	logic [63:0]   prod_s1;
	logic [31:0]   lo_q;
	logic [31:0]   hi_q;
	logic [31:0]   h_q;
	logic [AW:0]   rem_q;
	logic [31:0]   op_a;
	logic [31:0]   op_b;
	logic [AW:0]   rem_sh;
	logic [AW:0]   rem_nxt;

	always_comb begin
		case (step_q)
			SW'(0):  begin op_a = x_q[31:0];  op_b = MIX_MUL[31:0];  end
			SW'(1):  begin op_a = x_q[63:32]; op_b = MIX_MUL[31:0];  end
			default: begin op_a = x_q[31:0];  op_b = MIX_MUL[63:32]; end
		endcase
	end

	// one remainder bit a step, the shifted remainder stays below twice the table size
	assign rem_sh  = {rem_q[AW-1:0], h_q[31]};
	assign rem_nxt = (rem_sh >= (AW+1)'(SLOTS)) ? rem_sh - (AW+1)'(SLOTS) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(LAST)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q   <= key ^ {33'd0, key[63:MIX_SHIFT]};
			rem_q <= '0;
		end
		prod_s1 <= op_a * op_b;
		if (run_q) begin
			if (step_q == SW'(1)) begin
				lo_q <= prod_s1[31:0];
				hi_q <= prod_s1[63:32];
			end else if (step_q == SW'(2) || step_q == SW'(3)) begin
				hi_q <= hi_q + prod_s1[31:0];
			end else if (step_q == SW'(4)) begin
				// low word of m ^ (m >> 33)
				h_q <= lo_q ^ {1'b0, hi_q[31:1]};
			end else if (!POW2 && step_q > SW'(4)) begin
				rem_q <= rem_nxt;
				h_q   <= {h_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign home = POW2 ? h_q[AW-1:0] : rem_q[AW-1:0];

endmodule

FILE: sv/lphm_ctrl.sv
// controller: clearing pass, hashing, probe walk and outcome decision
module lphm_ctrl
	import lphm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  dp_stat_t  st,
	output ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		cmd.outcome = OC_MISSING;
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				cmd.load = start;
				if (start) state_nxt = S_HASH;
			end
			S_HASH: begin
				if (!st.key_ok) begin
					cmd.finish  = 1'b1;
					cmd.outcome = st.is_get ? OC_MISSING : OC_TYPE;
					state_nxt   = S_IDLE;
				end else if (st.hash_done) begin
					cmd.probe_load = 1'b1;
					state_nxt      = S_PROBE;
				end
			end
			S_PROBE: begin
				cmd.probe_run = 1'b1;
				if (st.ev_valid && (st.ev_hit || st.ev_empty || st.ev_last)) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
					if (st.is_get) begin
						cmd.outcome = st.ev_hit ? OC_GET_HIT : OC_MISSING;
					end else if (st.ev_hit) begin
						cmd.outcome = OC_OVERWRITE;
					end else if (st.ev_empty && !st.full) begin
						cmd.outcome = OC_INSERT;
					end else begin
						cmd.outcome = OC_FULL;
					end
				end
			end
			default: state_nxt = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: sv/lphm_dpath.sv
// datapath: slot memory, probe address walk, counters and result register
`include "assert_macros.svh"
module lphm_dpath
	import lphm_pkg::*;
#(
	parameter int SLOTS = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	input  in_item_t  item,
	output dp_stat_t  st,
	output logic      done,
	output out_item_t result
);

	localparam int AW    = $clog2(SLOTS);
	localparam int IW    = $clog2(SLOTS + 1);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int LIMIT = (SLOTS * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN;

	slot_t     mem_q [SLOTS];
	in_item_t  in_q;
	slot_t     rd_s1;
	logic      valid_s1;
	logic      last_s1;
	logic [AW-1:0] pos_s1;
	logic [AW-1:0] addr_q;
	logic [IW-1:0] iss_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] cnt_q;
	logic      hint_set_q;
	logic [3:0] hint_kind_q;
	logic      done_q;
	out_item_t res_q;

	logic      hash_done;
	logic [AW-1:0] home;
	logic      rd_en;
	logic      we;
	logic [AW-1:0] waddr;
	slot_t     wdata;
	logic      ins;
	logic      nxt_hint_set;
	logic [3:0] nxt_hint_kind;

	lphm_hash #(.SLOTS(SLOTS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.load),
		.key    (item.key),
		.done   (hash_done),
		.home   (home)
	);

	assign rd_en = cmd.probe_run && (iss_q != IW'(SLOTS));
	assign ins   = cmd.finish && (cmd.outcome == OC_INSERT);
	assign we    = cmd.clr || ins || (cmd.finish && (cmd.outcome == OC_OVERWRITE));
	assign waddr = cmd.clr ? clr_q : pos_s1;

	always_comb begin
		wdata = '0;
		if (!cmd.clr) begin
			wdata.used    = 1'b1;
			wdata.key     = in_q.key;
			wdata.tag     = in_q.value_tag;
			wdata.payload = in_q.value_payload;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (rd_en) rd_s1 <= mem_q[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= item;
		if (rd_en) begin
			pos_s1  <= addr_q;
			last_s1 <= (iss_q == IW'(SLOTS - 1));
		end
	end

	// probe walk, one slot issued a cycle, wraps at the end of the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			iss_q    <= '0;
			valid_s1 <= 1'b0;
			clr_q    <= '0;
		end else begin
			if (cmd.clr) clr_q <= clr_q + 1'b1;
			if (cmd.probe_load) begin
				addr_q   <= home;
				iss_q    <= '0;
				valid_s1 <= 1'b0;
			end else begin
				valid_s1 <= rd_en;
				if (rd_en) begin
					addr_q <= (addr_q == AW'(SLOTS - 1)) ? '0 : addr_q + 1'b1;
					iss_q  <= iss_q + 1'b1;
				end
			end
		end
	end

	assign nxt_hint_set  = hint_set_q || ins;
	assign nxt_hint_kind = (ins && !hint_set_q) ? in_q.value_tag : hint_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			hint_set_q  <= 1'b0;
			hint_kind_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (ins) begin
				cnt_q       <= cnt_q + 1'b1;
				hint_set_q  <= nxt_hint_set;
				hint_kind_q <= nxt_hint_kind;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.found          <= 1'b0;
			res_q.result_tag     <= '0;
			res_q.result_payload <= '0;
			res_q.hint_valid     <= nxt_hint_set;
			res_q.hint_kind      <= nxt_hint_kind;
			case (cmd.outcome)
				OC_TYPE:    res_q.status <= ST_TYPE;
				OC_FULL:    res_q.status <= ST_FULL;
				OC_MISSING: res_q.status <= ST_MISSING;
				OC_GET_HIT: begin
					res_q.status         <= ST_OK;
					res_q.found          <= 1'b1;
					res_q.result_tag     <= rd_s1.tag;
					res_q.result_payload <= rd_s1.payload;
				end
				OC_OVERWRITE: begin
					res_q.status <= ST_OK;
					res_q.found  <= 1'b1;
				end
				default: res_q.status <= ST_OK;
			endcase
		end
	end

	always_comb begin
		st           = '0;
		st.clr_last  = (clr_q == AW'(SLOTS - 1));
		st.key_ok    = in_q.key_is_integer;
		st.is_get    = (in_q.command == CMD_GET);
		st.hash_done = hash_done;
		st.ev_valid  = valid_s1;
		st.ev_hit    = rd_s1.used && (rd_s1.key == in_q.key);
		st.ev_empty  = !rd_s1.used;
		st.ev_last   = last_s1;
		st.full      = (cnt_q >= CW'(LIMIT));
	end

	assign done   = done_q;
	assign result = res_q;

	`ASSERT_IMP(a_cnt_limit, 1'b1, cnt_q <= CW'(LIMIT), "entry count above load limit")
	`ASSERT_NXT(a_done_single, done_q, !done_q, "result strobe longer than one cycle")
	`ASSERT_IMP(a_ins_empty, ins, valid_s1 && !rd_s1.used, "insert into a used slot")
	`ASSERT_NXT(a_hint_sticky, hint_set_q, hint_set_q, "kind hint cleared after being set")

endmodule

FILE: sv/linear_probe_hash_map_core.sv
// top level of the linear probing hash map with 64-bit integer keys
// Commands are taken when start is high and busy is low; each one answers with
// exactly one result, shown on result for the single cycle that done is high,
// and the receiver has no way to hold it off. After reset the block runs a
// clearing pass over every slot of the slot memory with busy high. For an item,
// the key is first mixed on one shared 32x32 multiplier, then the probe walk
// reads the slot memory one slot per cycle from the home slot, at least one
// slot, until it finds the key or an empty slot or has read every slot. A key
// of the wrong kind is answered from the hashing state, with no probe walk.
// When SLOTS is not a power of two the home slot reduction follows the mix.
// The next command may be accepted in the cycle that done is high.
module linear_probe_hash_map_core
	import lphm_pkg::*;
#(
	parameter int SLOTS = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      done,
	output out_item_t result
);

	ctrl_cmd_t cmd;
	dp_stat_t  st;

	lphm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	lphm_dpath #(.SLOTS(SLOTS)) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.st     (st),
		.done   (done),
		.result (result)
	);

endmodule
